@@ rtl/core/i2c_master_transaction_sequencer_defines.svh @@
// Assertion macros shared by the checker of the transaction sequencer
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define I2CMTS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i2cmts check failed");

// next-cycle implication checked outside reset
`define I2CMTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cmts check failed");

`endif

@@ rtl/core/i2cmts_pkg.sv @@
// Types and constants of the I2C master transaction sequencer
package i2cmts_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_LEN     = 16;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int LW          = $clog2(MAX_LEN);
    localparam int LENW        = 5;
    localparam int MAX_RES     = 5;
    localparam int RESW        = $clog2(MAX_RES + 1);
    localparam int JOB_DEPTH   = 4;
    localparam int JQW         = $clog2(JOB_DEPTH);
    localparam int JCW         = $clog2(JOB_DEPTH + 1);

    localparam logic [1:0] CMD_COMMIT = 2'd0;
    localparam logic [1:0] CMD_STAGE  = 2'd1;
    localparam logic [1:0] CMD_EVENT  = 2'd2;

    localparam logic [2:0] KIND_ADDR   = 3'd0;
    localparam logic [2:0] KIND_DATA   = 3'd1;
    localparam logic [2:0] KIND_CMD    = 3'd2;
    localparam logic [2:0] KIND_RXBYTE = 3'd3;
    localparam logic [2:0] KIND_FINISH = 3'd4;
    localparam logic [2:0] KIND_REJECT = 3'd5;

    localparam logic [7:0] C_RUN   = 8'h01;
    localparam logic [7:0] C_START = 8'h02;
    localparam logic [7:0] C_STOP  = 8'h04;
    localparam logic [7:0] C_ACK   = 8'h08;

    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;

    typedef struct packed {
        logic [7:0]      slave;
        logic [7:0]      reg_addr;
        logic [LENW-1:0] len;
        logic [7:0]      tag;
    } t_desc;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [7:0]      slave;
        logic [7:0]      reg_addr;
        logic [LENW-1:0] len;
        logic [7:0]      data;
        logic            addr_nack;
        logic            data_nack;
        logic [7:0]      tag;
    } t_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       success;
        logic [7:0] tag;
    } t_result;

    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [RESW-1:0]       cnt;
        logic                  mem_use;
        logic [RESW-1:0]       mem_pos;
    } t_job;

endpackage

@@ rtl/core/i2c_master_transaction_sequencer.sv @@
// Top level of the I2C master transaction sequencer
//
//  channel  | dir | tdata                                   | tuser | tlast
//  s_axis   | in  | slave,reg,length,data,nacks,tag (40b)   | cmd   | -
//  m_axis   | out | value,success,result_tag (24b)          | kind  | last
//
// An input item is taken every cycle while the job queue has room; its
// results leave one per cycle while m_axis is ready, and an item yields
// zero to five results, sent through the single result register of the back end.
// Results pass the front stage register, job queue, job and result registers.
// Reset (synchronous, active low) empties ring, staging and job queue.
// A stalled m_axis backs up the job queue and then s_axis.
module i2c_master_transaction_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] slave_address, [15:8] register_address, [20:16] length,
    // [28:21] data_byte, [29] addr_nack, [30] data_nack, [38:31] tag, [39] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] value, [8] success, [16:9] result_tag, [23:17] zero
    output logic [23:0] m_axis_tdata,
    // [2:0] kind
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    i2cmts_pkg::t_item          item;
    i2cmts_pkg::t_job           f_job, q_job;
    i2cmts_pkg::t_result        res;
    logic                       f_push, q_avail, b_pop;
    logic [i2cmts_pkg::JCW-1:0] q_count;

    always_comb begin
        item.cmd       = s_axis_tuser;
        item.slave     = s_axis_tdata[7:0];
        item.reg_addr  = s_axis_tdata[15:8];
        item.len       = s_axis_tdata[20:16];
        item.data      = s_axis_tdata[28:21];
        item.addr_nack = s_axis_tdata[29];
        item.data_nack = s_axis_tdata[30];
        item.tag       = s_axis_tdata[38:31];
    end

    i2cmts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (item),
        .i_q_count (q_count),
        .o_push    (f_push),
        .o_job     (f_job)
    );

    i2cmts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .i_pop   (b_pop),
        .o_job   (q_job),
        .o_avail (q_avail),
        .o_count (q_count)
    );

    i2cmts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_job),
        .i_avail (q_avail),
        .o_pop   (b_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, res.tag, res.success, res.value};
    assign m_axis_tuser = res.kind;

endmodule

@@ rtl/core/i2cmts_front.sv @@
// Front end: transaction ring, payload staging and result job building
module i2cmts_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  i2cmts_pkg::t_item          i_item,
    input  logic [i2cmts_pkg::JCW-1:0] i_q_count,
    output logic                       o_push,
    output i2cmts_pkg::t_job           o_job
);

    typedef enum logic [1:0] {PH_IDLE, PH_REG, PH_TX, PH_RX} t_phase;

    t_phase                             r_phase, n_phase;
    logic                               r_active, n_active;
    logic [i2cmts_pkg::LENW-1:0]        r_bi, n_bi;
    logic [i2cmts_pkg::QW-1:0]          r_head, n_head;
    logic [i2cmts_pkg::CW-1:0]          r_count, n_count;
    logic [i2cmts_pkg::LENW-1:0]        r_staged, n_staged;
    i2cmts_pkg::t_desc                  r_act, n_act;
    i2cmts_pkg::t_desc                  r_ring [i2cmts_pkg::QUEUE_DEPTH];
    logic [7:0] r_pay [i2cmts_pkg::QUEUE_DEPTH * i2cmts_pkg::MAX_LEN];
    logic [7:0]                         r_rd;
    logic                               r_s1_valid;
    i2cmts_pkg::t_job                   r_s1_job, job;

    logic                               acc, fin, fin_ok, st, ring_wr, pay_wr;
    i2cmts_pkg::t_desc                  st_desc, in_desc, nxt_desc;
    logic [i2cmts_pkg::QW-1:0]          tail;
    logic [i2cmts_pkg::QW+i2cmts_pkg::LW-1:0] rd_addr, wr_addr;
    logic [i2cmts_pkg::LENW-1:0]        bi1;

    function automatic i2cmts_pkg::t_job push(i2cmts_pkg::t_job j, logic [2:0] k,
                                              logic [7:0] v, logic ok, logic [7:0] t);
        i2cmts_pkg::t_job r;
        r = j;
        r.res[r.cnt] = '{kind: k, value: v, success: ok, tag: t};
        r.cnt = r.cnt + 1'b1;
        return r;
    endfunction

    assign acc      = i_valid && o_ready;
    assign o_ready  = ({1'b0, i_q_count} + {{i2cmts_pkg::JCW{1'b0}}, r_s1_valid})
                      < (i2cmts_pkg::JCW+1)'(i2cmts_pkg::JOB_DEPTH);
    assign tail     = r_head + r_count[i2cmts_pkg::QW-1:0];
    assign rd_addr  = {r_head, r_bi[i2cmts_pkg::LW-1:0]};
    assign wr_addr  = {tail, r_staged[i2cmts_pkg::LW-1:0]};
    assign nxt_desc = r_ring[r_head + 1'b1];
    assign bi1      = r_bi + 1'b1;

    always_comb begin
        in_desc.slave    = i_item.slave;
        in_desc.reg_addr = i_item.reg_addr;
        in_desc.len      = (i_item.len > i2cmts_pkg::LENW'(i2cmts_pkg::MAX_LEN))
                           ? i2cmts_pkg::LENW'(i2cmts_pkg::MAX_LEN) : i_item.len;
        in_desc.tag      = i_item.tag;
    end

    always_comb begin
        n_phase  = r_phase;
        n_active = r_active;
        n_bi     = r_bi;
        n_head   = r_head;
        n_count  = r_count;
        n_staged = r_staged;
        n_act    = r_act;
        job      = '0;
        fin      = 1'b0;
        fin_ok   = 1'b0;
        st       = 1'b0;
        st_desc  = in_desc;
        ring_wr  = 1'b0;
        pay_wr   = 1'b0;
        if (acc) begin
            unique case (i_item.cmd)
                i2cmts_pkg::CMD_COMMIT: begin
                    if (r_count >= i2cmts_pkg::CW'(i2cmts_pkg::QUEUE_DEPTH)) begin
                        job = push(job, i2cmts_pkg::KIND_REJECT, 8'd0, 1'b0, i_item.tag);
                    end else begin
                        ring_wr = 1'b1;
                        n_count = r_count + 1'b1;
                        st      = !r_active;
                    end
                    n_staged = '0;
                end
                i2cmts_pkg::CMD_STAGE: begin
                    if (r_count < i2cmts_pkg::CW'(i2cmts_pkg::QUEUE_DEPTH) &&
                        r_staged < i2cmts_pkg::LENW'(i2cmts_pkg::MAX_LEN)) begin
                        pay_wr   = 1'b1;
                        n_staged = r_staged + 1'b1;
                    end
                end
                i2cmts_pkg::CMD_EVENT: begin
                    if (r_active) begin
                        if (i_item.addr_nack || i_item.data_nack) begin
                            job = push(job, i2cmts_pkg::KIND_CMD, i2cmts_pkg::C_STOP,
                                       1'b0, r_act.tag);
                            fin = 1'b1;
                        end else begin
                            unique case (r_phase)
                                PH_REG: begin
                                    if (r_act.slave[0]) begin
                                        n_phase = PH_RX;
                                        n_bi    = '0;
                                        job = push(job, i2cmts_pkg::KIND_ADDR, r_act.slave,
                                                   1'b0, r_act.tag);
                                        job = push(job, i2cmts_pkg::KIND_CMD,
                                            (r_act.len == 1)
                                            ? (i2cmts_pkg::C_START | i2cmts_pkg::C_RUN |
                                               i2cmts_pkg::C_STOP)
                                            : (i2cmts_pkg::C_ACK | i2cmts_pkg::C_START |
                                               i2cmts_pkg::C_RUN), 1'b0, r_act.tag);
                                    end else begin
                                        n_phase = PH_TX;
                                        job = push(job, i2cmts_pkg::KIND_ADDR,
                                                   r_act.slave & i2cmts_pkg::ADDR_WRITE_MASK,
                                                   1'b0, r_act.tag);
                                        job.mem_use = 1'b1;
                                        job.mem_pos = job.cnt;
                                        job = push(job, i2cmts_pkg::KIND_DATA, 8'd0,
                                                   1'b0, r_act.tag);
                                        n_bi = i2cmts_pkg::LENW'(1);
                                        job = push(job, i2cmts_pkg::KIND_CMD,
                                            (r_act.len == 1)
                                            ? (i2cmts_pkg::C_RUN | i2cmts_pkg::C_STOP)
                                            : i2cmts_pkg::C_RUN, 1'b0, r_act.tag);
                                    end
                                end
                                PH_TX: begin
                                    if (r_bi < r_act.len) begin
                                        job.mem_use = 1'b1;
                                        job.mem_pos = job.cnt;
                                        job = push(job, i2cmts_pkg::KIND_DATA, 8'd0,
                                                   1'b0, r_act.tag);
                                        n_bi = bi1;
                                        job = push(job, i2cmts_pkg::KIND_CMD,
                                            (bi1 == r_act.len)
                                            ? (i2cmts_pkg::C_RUN | i2cmts_pkg::C_STOP)
                                            : i2cmts_pkg::C_RUN, 1'b0, r_act.tag);
                                    end else begin
                                        fin    = 1'b1;
                                        fin_ok = 1'b1;
                                    end
                                end
                                PH_RX: begin
                                    if (r_bi < r_act.len) begin
                                        job = push(job, i2cmts_pkg::KIND_RXBYTE,
                                                   i_item.data, 1'b0, r_act.tag);
                                        n_bi = bi1;
                                    end
                                    if (n_bi < r_act.len) begin
                                        job = push(job, i2cmts_pkg::KIND_CMD,
                                            (n_bi == r_act.len - 1'b1)
                                            ? (i2cmts_pkg::C_STOP | i2cmts_pkg::C_RUN)
                                            : (i2cmts_pkg::C_ACK | i2cmts_pkg::C_RUN),
                                            1'b0, r_act.tag);
                                    end else begin
                                        fin    = 1'b1;
                                        fin_ok = 1'b1;
                                    end
                                end
                                default: begin
                                    fin    = 1'b1;
                                    fin_ok = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase
            if (fin) begin
                job = push(job, i2cmts_pkg::KIND_FINISH, 8'd0, fin_ok, r_act.tag);
                n_active = 1'b0;
                n_phase  = PH_IDLE;
                n_bi     = '0;
                n_head   = r_head + 1'b1;
                n_count  = r_count - 1'b1;
                st       = (n_count != '0);
                st_desc  = nxt_desc;
            end
            if (st) begin
                n_active = 1'b1;
                n_bi     = '0;
                n_act    = st_desc;
                job = push(job, i2cmts_pkg::KIND_ADDR,
                           st_desc.slave & i2cmts_pkg::ADDR_WRITE_MASK, 1'b0, st_desc.tag);
                job = push(job, i2cmts_pkg::KIND_DATA, st_desc.reg_addr, 1'b0, st_desc.tag);
                if (st_desc.len == '0) begin
                    n_phase = PH_TX;
                    job = push(job, i2cmts_pkg::KIND_CMD,
                               i2cmts_pkg::C_START | i2cmts_pkg::C_RUN | i2cmts_pkg::C_STOP,
                               1'b0, st_desc.tag);
                end else begin
                    n_phase = PH_REG;
                    job = push(job, i2cmts_pkg::KIND_CMD,
                               i2cmts_pkg::C_START | i2cmts_pkg::C_RUN, 1'b0, st_desc.tag);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_active   <= 1'b0;
            r_bi       <= '0;
            r_head     <= '0;
            r_count    <= '0;
            r_staged   <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_active   <= n_active;
            r_bi       <= n_bi;
            r_head     <= n_head;
            r_count    <= n_count;
            r_staged   <= n_staged;
            r_s1_valid <= acc;
        end
        r_act <= n_act;
        if (acc) begin
            r_s1_job <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_wr) begin
            r_ring[tail] <= in_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pay_wr) begin
            r_pay[wr_addr] <= i_item.data;
        end
        if (acc) begin
            r_rd <= r_pay[rd_addr];
        end
    end

    always_comb begin
        o_job  = r_s1_job;
        if (r_s1_job.mem_use) begin
            o_job.res[r_s1_job.mem_pos].value = r_rd;
        end
        o_push = r_s1_valid && (r_s1_job.cnt != '0);
    end

endmodule

@@ rtl/core/i2cmts_queue.sv @@
// Job queue between the front end and the result serializer
module i2cmts_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  i2cmts_pkg::t_job           i_job,
    input  logic                       i_pop,
    output i2cmts_pkg::t_job           o_job,
    output logic                       o_avail,
    output logic [i2cmts_pkg::JCW-1:0] o_count
);

    i2cmts_pkg::t_job           r_mem [i2cmts_pkg::JOB_DEPTH];
    logic [i2cmts_pkg::JQW-1:0] r_rd, r_wr;
    logic [i2cmts_pkg::JCW-1:0] r_count;
    logic                       pop;

    assign pop     = i_pop && (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign o_avail = (r_count != '0);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + {{(i2cmts_pkg::JCW-1){1'b0}}, i_push}
                               - {{(i2cmts_pkg::JCW-1){1'b0}}, pop};
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

@@ rtl/core/i2cmts_back.sv @@
// Back end: serializes each job into result transfers with an output register
module i2cmts_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cmts_pkg::t_job     i_job,
    input  logic                 i_avail,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output i2cmts_pkg::t_result  o_res,
    output logic                 o_last
);

    i2cmts_pkg::t_job            r_job;
    logic                        r_busy;
    logic [i2cmts_pkg::RESW-1:0] r_pos;
    logic                        r_valid;
    i2cmts_pkg::t_result         r_res;
    logic                        r_last;
    logic                        slot_free, emit, is_last;

    assign slot_free = !r_valid || i_ready;
    assign emit      = slot_free && r_busy;
    assign is_last   = (r_pos == r_job.cnt - 1'b1);
    assign o_pop     = i_avail && (!r_busy || (emit && is_last));
    assign o_valid   = r_valid;
    assign o_res     = r_res;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (slot_free) begin
                r_valid <= emit;
            end
            if (emit) begin
                r_pos <= r_pos + 1'b1;
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end
        end
        if (emit) begin
            r_res  <= r_job.res[r_pos];
            r_last <= is_last;
        end
        if (o_pop) begin
            r_job <= i_job;
        end
    end

endmodule

@@ rtl/core/i2cmts_checker.sv @@
// Port-level checks of the transaction sequencer and their binding
`include "i2c_master_transaction_sequencer_defines.svh"

module i2cmts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `I2CMTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `I2CMTS_ASSERT(a_kind_range, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tuser <= i2cmts_pkg::KIND_REJECT))
    `I2CMTS_ASSERT(a_reject_alone, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser == i2cmts_pkg::KIND_REJECT) |-> (m_axis_tlast && m_axis_tdata[8:0] == 9'd0))
    `I2CMTS_ASSERT(a_success_finish, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tuser == i2cmts_pkg::KIND_FINISH))

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/i2c_master_transaction_sequencer_checker.sv @@
// Checker: predicts the result stream of the transaction sequencer and compares it
module i2c_master_transaction_sequencer_checker
    import i2cmts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic [2:0]  i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef enum logic [1:0] {PH_IDLE, PH_REG, PH_TX, PH_RX} t_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       success;
        logic [7:0] tag;
        logic       last;
    } t_exp;

    t_exp       exp_q[$];
    t_exp       step_res[MAX_RES];
    int         step_n;

    t_phase     phase;
    logic       active;
    logic [4:0] byte_idx;
    t_desc      ring[QUEUE_DEPTH];
    logic [QW-1:0] head;
    logic [CW-1:0] count;
    logic [4:0] staged;
    logic [7:0] payload[QUEUE_DEPTH][MAX_LEN];

    assign o_pending = exp_q.size();

    task automatic emit(input logic [2:0] k, input logic [7:0] v, input logic s,
                        input logic [7:0] t);
        if (step_n < MAX_RES) begin
            step_res[step_n] = '{kind: k, value: v, success: s, tag: t, last: 1'b0};
            step_n++;
        end
    endtask

    task automatic launch();
        t_desc d;
        d = ring[head];
        active   = 1'b1;
        byte_idx = '0;
        emit(KIND_ADDR, d.slave & ADDR_WRITE_MASK, 1'b0, d.tag);
        emit(KIND_DATA, d.reg_addr, 1'b0, d.tag);
        if (d.len == 0) begin
            phase = PH_TX;
            emit(KIND_CMD, C_START | C_RUN | C_STOP, 1'b0, d.tag);
        end else begin
            phase = PH_REG;
            emit(KIND_CMD, C_START | C_RUN, 1'b0, d.tag);
        end
    endtask

    task automatic retire(input logic ok, input logic [7:0] t);
        emit(KIND_FINISH, 8'h00, ok, t);
        active   = 1'b0;
        phase    = PH_IDLE;
        byte_idx = '0;
        head     = head + 1'b1;
        if (count > 0) count--;
        if (count > 0) launch();
    endtask

    task automatic on_event(input t_item it);
        t_desc d;
        if (!active) return;
        d = ring[head];
        if (it.addr_nack || it.data_nack) begin
            emit(KIND_CMD, C_STOP, 1'b0, d.tag);
            retire(1'b0, d.tag);
            return;
        end
        case (phase)
            PH_REG: begin
                if (d.slave[0]) begin
                    phase    = PH_RX;
                    byte_idx = '0;
                    emit(KIND_ADDR, d.slave, 1'b0, d.tag);
                    emit(KIND_CMD, d.len == 1 ? (C_START | C_RUN | C_STOP)
                                              : (C_ACK | C_START | C_RUN), 1'b0, d.tag);
                end else begin
                    phase = PH_TX;
                    emit(KIND_ADDR, d.slave & ADDR_WRITE_MASK, 1'b0, d.tag);
                    emit(KIND_DATA, payload[head][0], 1'b0, d.tag);
                    byte_idx = 5'd1;
                    emit(KIND_CMD, d.len == 1 ? (C_RUN | C_STOP) : C_RUN, 1'b0, d.tag);
                end
            end
            PH_TX: begin
                if (byte_idx < d.len) begin
                    emit(KIND_DATA, payload[head][byte_idx[LW-1:0]], 1'b0, d.tag);
                    byte_idx++;
                    emit(KIND_CMD, byte_idx == d.len ? (C_RUN | C_STOP) : C_RUN,
                         1'b0, d.tag);
                end else begin
                    retire(1'b1, d.tag);
                end
            end
            PH_RX: begin
                if (byte_idx < d.len) begin
                    emit(KIND_RXBYTE, it.data, 1'b0, d.tag);
                    byte_idx++;
                end
                if (byte_idx < d.len)
                    emit(KIND_CMD, byte_idx == d.len - 1 ? (C_STOP | C_RUN)
                                                         : (C_ACK | C_RUN), 1'b0, d.tag);
                else
                    retire(1'b1, d.tag);
            end
            default: retire(1'b1, d.tag);
        endcase
    endtask

    task automatic predict(input t_item it);
        logic [QW-1:0] slot;
        logic [4:0]    len;
        step_n = 0;
        slot = head + count[QW-1:0];
        if (it.cmd == CMD_COMMIT) begin
            if (count >= QUEUE_DEPTH) begin
                emit(KIND_REJECT, 8'h00, 1'b0, it.tag);
            end else begin
                len = it.len > MAX_LEN ? 5'(MAX_LEN) : it.len;
                ring[slot] = '{slave: it.slave, reg_addr: it.reg_addr, len: len,
                               tag: it.tag};
                count++;
                if (!active) launch();
            end
            staged = '0;
        end else if (it.cmd == CMD_STAGE) begin
            if (count < QUEUE_DEPTH && staged < MAX_LEN) begin
                payload[slot][staged[LW-1:0]] = it.data;
                staged++;
            end
        end else if (it.cmd == CMD_EVENT) begin
            on_event(it);
        end
        if (step_n > 0) step_res[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++) exp_q.push_back(step_res[i]);
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        t_item it;
        t_exp  e;
        if (!i_rst_n) begin
            phase    = PH_IDLE;
            active   = 1'b0;
            byte_idx = '0;
            head     = '0;
            count    = '0;
            staged   = '0;
            exp_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                it.cmd       = i_s_tuser;
                it.slave     = i_s_tdata[7:0];
                it.reg_addr  = i_s_tdata[15:8];
                it.len       = i_s_tdata[20:16];
                it.data      = i_s_tdata[28:21];
                it.addr_nack = i_s_tdata[29];
                it.data_nack = i_s_tdata[30];
                it.tag       = i_s_tdata[38:31];
                predict(it);
            end
            if (i_m_tvalid && i_m_tready) begin
                o_checked++;
                if (exp_q.size() == 0) begin
                    report("unexpected result kind", i_m_tuser, 0);
                end else begin
                    e = exp_q.pop_front();
                    if (i_m_tuser != e.kind) report("kind", i_m_tuser, e.kind);
                    if (i_m_tdata[7:0] != e.value) report("value", i_m_tdata[7:0], e.value);
                    if (i_m_tdata[8] != e.success) report("success", i_m_tdata[8], e.success);
                    if (i_m_tdata[16:9] != e.tag) report("result_tag", i_m_tdata[16:9], e.tag);
                    if (i_m_tdata[23:17] != 0) report("pad bits", i_m_tdata[23:17], 0);
                    if (i_m_tlast != e.last) report("last", i_m_tlast, e.last);
                end
            end
        end
    end

endmodule

@@ sim/testbench.sv @@
// Testbench top: stimulus, flow control and verdict for the transaction sequencer
module testbench;
    import i2cmts_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int checked;
    int cycles;
    int sent;
    int xacts;
    int src_idle;
    int snk_idle;
    logic hold_req;

    i2c_master_transaction_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    i2c_master_transaction_sequencer_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // sink side: random stalls, plus a long hold-off on request
    initial begin
        int left;
        m_axis_tready = 1'b0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && left == 0) left = 400;
            if (left > 0) begin
                left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    task automatic send(input logic [1:0] cmd, input logic [7:0] slave,
                        input logic [7:0] reg_addr, input logic [4:0] len,
                        input logic [7:0] data, input logic an, input logic dn,
                        input logic [7:0] tag);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, tag, dn, an, data, len, reg_addr, slave};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic stage(input logic [7:0] b);
        send(CMD_STAGE, 8'($urandom), 8'($urandom), 5'($urandom), b, 1'($urandom),
             1'($urandom), 8'($urandom));
    endtask

    task automatic ctl_event(input logic an, input logic dn);
        send(CMD_EVENT, 8'($urandom), 8'($urandom), 5'($urandom), 8'($urandom), an, dn,
             8'($urandom));
    endtask

    // stage nstage bytes, commit, then play the controller for len+1 events;
    // nack_at >= 0 puts a NACK on that event
    task automatic xact(input logic [7:0] slave, input logic [4:0] len,
                        input int nstage, input int nack_at);
        logic an;
        for (int i = 0; i < nstage; i++) stage(8'($urandom));
        send(CMD_COMMIT, slave, 8'($urandom), len, 8'($urandom), 1'($urandom),
             1'($urandom), 8'($urandom));
        xacts++;
        for (int i = 0; i <= len; i++) begin
            an = 1'($urandom_range(1));
            if (i == nack_at) begin
                ctl_event(an, ~an);
                break;
            end
            ctl_event(1'b0, 1'b0);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        int len;
        int act;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_COMMIT;
        hold_req      = 1'b0;
        sent          = 0;
        xacts         = 0;
        src_idle      = 17;
        snk_idle      = 77;
        i_rst_n       = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill every payload slot once via zero-length transactions
        for (int s = 0; s < QUEUE_DEPTH; s++) begin
            for (int i = 0; i < MAX_LEN; i++) stage(i[0] ? 8'hFF : 8'h00);
            send(CMD_COMMIT, 8'hFF, 8'h00, 5'd0, 8'h00, 1'b0, 1'b0, 8'(s));
            ctl_event(1'b0, 1'b0);
        end
        ctl_event(1'b0, 1'b0);                 // no active transaction
        xact(8'hFE, 5'd1, 1, -1);
        xact(8'h00, 5'd16, 17, -1);            // one byte beyond the limit
        xact(8'h01, 5'd1, 0, -1);
        xact(8'hFF, 5'd16, 0, -1);
        xact(8'h54, 5'd4, 2, -1);              // short staging
        send(CMD_COMMIT, 8'hA0, 8'hFF, 5'd3, 8'h00, 1'b0, 1'b0, 8'h11);
        ctl_event(1'b1, 1'b0);
        send(CMD_COMMIT, 8'hA1, 8'h7F, 5'd3, 8'h00, 1'b0, 1'b0, 8'h22);
        ctl_event(1'b0, 1'b0);
        ctl_event(1'b0, 1'b1);
        // queue full: active plus three queued, then a reject
        for (int i = 0; i < QUEUE_DEPTH + 1; i++)
            send(CMD_COMMIT, 8'(2 * i), 8'(i), 5'd0, 8'h00, 1'b0, 1'b0, 8'hF0 + 8'(i));
        stage(8'hAA);                          // staging while full
        for (int i = 0; i < QUEUE_DEPTH; i++) ctl_event(1'b0, 1'b0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 17 : (ph == 1) ? 77 : 0;
            snk_idle = (ph == 0) ? 77 : (ph == 1) ? 17 : 0;
            for (int n = 0; n < 8; n++) begin
                act = int'($urandom_range(99));
                len = ($urandom_range(9) == 0) ? MAX_LEN : int'($urandom_range(4));
                if (ph == 2 && n == 5) hold_req = 1'b1;
                if (ph == 2 && n == 6) hold_req = 1'b0;
                if (act < 70) begin
                    xact(8'($urandom), 5'(len),
                         ($urandom_range(3) == 0) ? int'($urandom_range(MAX_LEN + 1)) : len,
                         ($urandom_range(9) == 0) ? int'($urandom_range(len)) : -1);
                end else if (act < 80) begin
                    repeat ($urandom_range(1, 6))
                        send(CMD_COMMIT, 8'($urandom), 8'($urandom), 5'($urandom_range(2)),
                             8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
                end else if (act < 92) begin
                    repeat ($urandom_range(1, 5))
                        ctl_event($urandom_range(7) == 0, $urandom_range(7) == 0);
                end else begin
                    repeat ($urandom_range(1, 4)) stage(8'($urandom));
                end
                if (n == 4) drain();
            end
            repeat (12) ctl_event(1'b0, 1'b0);
            drain();
        end

        repeat (20) @(negedge i_clk);
        $display("sent %0d input transfers, %0d sequenced transactions", sent, xacts);
        $display("checked %0d result transfers under three flow-control mixes", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
